/* design/bps_pkg.sv */
// Shared types and constants for the byte pattern scanner.
`default_nettype none

package bps_pkg;

   localparam int PATTERN_MAX_DEFAULT  = 32;
   localparam int ADDRESS_BITS_DEFAULT = 48;

   localparam int PATTERN_WORDS   = 4;
   localparam int PATTERN_BYTES   = 32;
   localparam int LENGTH_BITS     = 6;
   localparam int COUNT_BITS      = 16;
   localparam int CSR_DATA_BITS   = 64;
   localparam int CSR_ADDR_BITS   = 6;
   localparam int CSR_INDEX_LSB   = 3;
   localparam int CSR_INDEX_BITS  = 3;

   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_LOW    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_MID    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_UPPER  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_TOP    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_LENGTH = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_QUIT_ON_FIRST  = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RESULT_LIMIT   = 3'd6;

   localparam logic [LENGTH_BITS-1:0] PATTERN_LENGTH_RESET = 6'd1;
   localparam logic [COUNT_BITS-1:0]  RESULT_LIMIT_RESET   = 16'd255;
   localparam logic [COUNT_BITS-1:0]  COUNT_SATURATED      = 16'hFFFF;

   typedef enum logic [1:0] {
      KIND_MATCH     = 2'd0,
      KIND_STOPPED   = 2'd1,
      KIND_DONE      = 2'd2,
      KIND_NOT_FOUND = 2'd3
   } result_kind_type;

   typedef struct packed {
      result_kind_type         kind;
      logic [COUNT_BITS-1:0]   count;
      logic                    last;
   } result_info_type;

endpackage

`default_nettype wire

/* design/byte_pattern_scanner_top.sv */
// Byte pattern scanner: streaming exact match of a configured byte pattern.
//
// Usage: bytes enter on the req_ channel (valid/ready), one item per byte, with
// its address, a page_start flag that clears the match window, and an
// end_of_scan flag that closes the scan. Results leave on the rsp_ channel:
// a match (start address, running count), a stop status after the first match
// in quit-on-first mode or at the result limit, and a found/not-found status
// at end of scan. One item gives zero, one or two results.
// The window compare for a byte is done in the cycle it is accepted; its
// results are registered in a 4-entry result queue whose head drives rsp_.
// One byte is accepted every cycle while the queue has room for two results;
// the rsp_ port pops one result a cycle while rsp_ready is high, so the two
// results of one item leave one after the other.
// When the receiver stalls, the queue fills and req_ready drops once fewer
// than two entries are free; nothing is lost.
// Configuration goes through the csr_ APB port, registers at 8-byte spacing;
// write only while idle. Reset (synchronous) clears the window, counters,
// queue and stop flag, and returns registers to their reset values.
`default_nettype none

module byte_pattern_scanner_top #(
   parameter int PATTERN_MAX  = bps_pkg::PATTERN_MAX_DEFAULT,
   parameter int ADDRESS_BITS = bps_pkg::ADDRESS_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [7:0]                            req_data_byte,
   input  wire logic [ADDRESS_BITS-1:0]               req_byte_address,
   input  wire logic                                  req_page_start,
   input  wire logic                                  req_end_of_scan,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [1:0]                                 rsp_result_kind,
   output logic [ADDRESS_BITS-1:0]                    rsp_match_address,
   output logic [bps_pkg::COUNT_BITS-1:0]             rsp_match_count,
   output logic                                       rsp_last_result,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [bps_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  wire logic [bps_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [bps_pkg::CSR_DATA_BITS-1:0]          csr_prdata,
   output logic                                       csr_pready
);

   localparam int LW = $clog2(PATTERN_MAX + 1);
   localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int CW = (LW > bps_pkg::LENGTH_BITS) ? LW : bps_pkg::LENGTH_BITS;
   localparam int CB = bps_pkg::COUNT_BITS;
   localparam int QDEPTH = 4;
   localparam int QPW = 2;
   localparam int QCW = 3;

   // configuration registers
   logic [bps_pkg::PATTERN_WORDS-1:0][bps_pkg::CSR_DATA_BITS-1:0] pat_words_ff;
   logic [bps_pkg::LENGTH_BITS-1:0] pat_len_ff;
   logic                            quit_ff;
   logic [CB-1:0]                   limit_ff;

   logic                                csr_write;
   logic [bps_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [bps_pkg::PATTERN_BYTES*8-1:0] pat_flat;

   // scan state
   logic [7:0]    win_ff [PATTERN_MAX];
   logic [7:0]    win_in [PATTERN_MAX];
   logic [LW-1:0] bip_ff, bip_in;
   logic [CB-1:0] found_ff, found_in;
   logic          stopped_ff;

   // result queue
   bps_pkg::result_info_type q_info_ff [QDEPTH];
   logic [ADDRESS_BITS-1:0]  q_addr_ff [QDEPTH];
   logic [QPW-1:0]           q_wr_ff, q_rd_ff;
   logic [QCW-1:0]           q_cnt_ff;

   logic [7:0]              pat_byte [PATTERN_MAX];
   logic [CW-1:0]           len_wide, pl_wide;
   logic [LW-1:0]           len;
   logic [LW-1:0]           idx;
   logic                    all_eq;
   logic                    hit;
   logic                    stop_now;
   logic                    accept;
   logic                    pop;
   logic                    process;
   logic [1:0]              n_push;
   bps_pkg::result_info_type push0_info, push1_info;
   logic [ADDRESS_BITS-1:0] push0_addr;
   logic [ADDRESS_BITS-1:0] match_addr;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[bps_pkg::CSR_INDEX_LSB +: bps_pkg::CSR_INDEX_BITS];
   assign pat_flat   = pat_words_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_words_ff <= '0;
         pat_len_ff   <= bps_pkg::PATTERN_LENGTH_RESET;
         quit_ff      <= 1'b0;
         limit_ff     <= bps_pkg::RESULT_LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            bps_pkg::REG_PATTERN_LOW:    pat_words_ff[0] <= csr_pwdata;
            bps_pkg::REG_PATTERN_MID:    pat_words_ff[1] <= csr_pwdata;
            bps_pkg::REG_PATTERN_UPPER:  pat_words_ff[2] <= csr_pwdata;
            bps_pkg::REG_PATTERN_TOP:    pat_words_ff[3] <= csr_pwdata;
            bps_pkg::REG_PATTERN_LENGTH: pat_len_ff <= csr_pwdata[bps_pkg::LENGTH_BITS-1:0];
            bps_pkg::REG_QUIT_ON_FIRST:  quit_ff    <= csr_pwdata[0];
            bps_pkg::REG_RESULT_LIMIT:   limit_ff   <= csr_pwdata[CB-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         bps_pkg::REG_PATTERN_LOW:    csr_prdata = pat_words_ff[0];
         bps_pkg::REG_PATTERN_MID:    csr_prdata = pat_words_ff[1];
         bps_pkg::REG_PATTERN_UPPER:  csr_prdata = pat_words_ff[2];
         bps_pkg::REG_PATTERN_TOP:    csr_prdata = pat_words_ff[3];
         bps_pkg::REG_PATTERN_LENGTH:
            csr_prdata = bps_pkg::CSR_DATA_BITS'(pat_len_ff);
         bps_pkg::REG_QUIT_ON_FIRST:  csr_prdata = bps_pkg::CSR_DATA_BITS'(quit_ff);
         bps_pkg::REG_RESULT_LIMIT:   csr_prdata = bps_pkg::CSR_DATA_BITS'(limit_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   // ---------------- pattern bytes, zero past the stored 32 ----------------
   for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_pat
      if (g < bps_pkg::PATTERN_BYTES) begin : g_stored
         assign pat_byte[g] = pat_flat[g*8 +: 8];
      end else begin : g_zero
         assign pat_byte[g] = 8'h00;
      end
   end

   // ---------------- window compare ----------------
   always_comb begin
      pl_wide = CW'(pat_len_ff);
      if (pl_wide == '0) begin
         len_wide = CW'(1);
      end else if (pl_wide > CW'(PATTERN_MAX)) begin
         len_wide = CW'(PATTERN_MAX);
      end else begin
         len_wide = pl_wide;
      end
   end
   assign len = LW'(len_wide);

   always_comb begin
      win_in[0] = req_data_byte;
      for (int i = 1; i < PATTERN_MAX; i++) begin
         win_in[i] = req_page_start ? 8'h00 : win_ff[i-1];
      end
      if (req_page_start) begin
         bip_in = LW'(1);
      end else if (bip_ff < LW'(PATTERN_MAX)) begin
         bip_in = bip_ff + LW'(1);
      end else begin
         bip_in = bip_ff;
      end
   end

   always_comb begin
      all_eq = 1'b1;
      idx    = '0;
      for (int k = 0; k < PATTERN_MAX; k++) begin
         idx = len - LW'(1) - LW'(k);
         if (LW'(k) < len) begin
            if (win_in[idx[IW-1:0]] != pat_byte[k]) begin
               all_eq = 1'b0;
            end
         end
      end
   end

   assign hit        = (bip_in >= len) && all_eq;
   assign found_in   = (found_ff == bps_pkg::COUNT_SATURATED) ? found_ff
                                                              : found_ff + CB'(1);
   assign stop_now   = quit_ff || (found_in >= limit_ff);
   assign match_addr = req_byte_address - ADDRESS_BITS'(len - LW'(1));

   // ---------------- handshake and result generation ----------------
   assign req_ready = (q_cnt_ff <= QCW'(QDEPTH - 2));
   assign accept    = req_valid & req_ready;
   assign process   = accept & ~req_end_of_scan & ~stopped_ff;
   assign rsp_valid = (q_cnt_ff != '0);
   assign pop       = rsp_valid & rsp_ready;

   always_comb begin
      n_push     = 2'd0;
      push0_info = '{kind: bps_pkg::KIND_MATCH, count: found_in, last: 1'b1};
      push1_info = '{kind: bps_pkg::KIND_STOPPED, count: found_in, last: 1'b1};
      push0_addr = match_addr;
      if (accept && req_end_of_scan) begin
         n_push          = 2'd1;
         push0_info.kind = (found_ff != '0) ? bps_pkg::KIND_DONE
                                            : bps_pkg::KIND_NOT_FOUND;
         push0_info.count = found_ff;
         push0_addr      = '0;
      end else if (process && hit) begin
         if (stop_now) begin
            n_push          = 2'd2;
            push0_info.last = 1'b0;
         end else begin
            n_push = 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PATTERN_MAX; i++) begin
            win_ff[i] <= 8'h00;
         end
         bip_ff     <= '0;
         found_ff   <= '0;
         stopped_ff <= 1'b0;
      end else if (accept && req_end_of_scan) begin
         for (int i = 0; i < PATTERN_MAX; i++) begin
            win_ff[i] <= 8'h00;
         end
         bip_ff     <= '0;
         found_ff   <= '0;
         stopped_ff <= 1'b0;
      end else if (process) begin
         win_ff <= win_in;
         bip_ff <= bip_in;
         if (hit) begin
            found_ff <= found_in;
            if (stop_now) begin
               stopped_ff <= 1'b1;
            end
         end
      end
   end

   // ---------------- result queue ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff  <= '0;
         q_rd_ff  <= '0;
         q_cnt_ff <= '0;
      end else begin
         q_wr_ff  <= q_wr_ff + QPW'(n_push);
         q_rd_ff  <= q_rd_ff + QPW'(pop);
         q_cnt_ff <= q_cnt_ff + QCW'(n_push) - QCW'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         q_info_ff[q_wr_ff] <= push0_info;
         q_addr_ff[q_wr_ff] <= push0_addr;
      end
      if (n_push == 2'd2) begin
         q_info_ff[q_wr_ff + QPW'(1)] <= push1_info;
         q_addr_ff[q_wr_ff + QPW'(1)] <= '0;
      end
   end

   assign rsp_result_kind   = q_info_ff[q_rd_ff].kind;
   assign rsp_match_count   = q_info_ff[q_rd_ff].count;
   assign rsp_last_result   = q_info_ff[q_rd_ff].last;
   assign rsp_match_address = q_addr_ff[q_rd_ff];

endmodule

`default_nettype wire
